### rtl/core/image_mse_psnr_assert.svh
// Assertion macros shared by the image MSE/PSNR RTL.
`ifndef IMAGE_MSE_PSNR_ASSERT_SVH
`define IMAGE_MSE_PSNR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("image_mse_psnr: implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("image_mse_psnr: next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### rtl/core/imp_pkg.sv
// Types and constants of the image MSE/PSNR block.
package imp_pkg;
    localparam int unsigned SUM_W    = 54;
    localparam int unsigned MSE_W    = 40;
    localparam int unsigned PSNR_W   = 17;
    localparam int unsigned LOG_W    = 30;
    localparam int unsigned DVD_W    = 63;
    localparam logic [31:0] DB_SCALE = 32'd808071242;
    localparam logic [PSNR_W-1:0] PSNR_IDENT = 17'h1FF00;
    localparam logic [4:0] DEPTH_RESET = 5'd8;

    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [LOG_W-1:0]  t_log;
    typedef logic [PSNR_W-1:0] t_psnr;
endpackage

### rtl/core/image_mse_psnr.sv
// Image MSE/PSNR accumulator with an iterative log, multiply and divide sequencer.
//
//  channel   dir  handshake              payload
//  s         in   i_s_tvalid/o_s_tready  tdata: pixel_a, pixel_b; tlast: last
//  m         out  o_m_tvalid/i_m_tready  tdata: mse, psnr; tuser: identical, overflow
//  cfg       in   i_cfg_wen              i_cfg_wdata: bit_depth
//
// A beat is squared on the shared 32x32 multiplier, then added with saturation;
// a beat that arrives once the pair count has reached MAX_PIXELS skips both.
// A last beat adds the finish: two logs, each a normalize shift plus 24
// squarings on the same multiplier, then a restoring divide of the 63-bit
// dividend. An identical frame skips the logs and the divide.
// Reset is synchronous, active low. The result waits in the output register
// and the block sits in its output state until that register is free.
`include "image_mse_psnr_assert.svh"
module image_mse_psnr
    import imp_pkg::*;
#(
    parameter int unsigned MAX_PIXELS  = 4194304,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] pixel_a, [31:16] pixel_b
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [39:0] mse, [56:40] psnr, rest zero
    output logic [1:0]  o_m_tuser    // [0] identical, [1] overflow
);
    localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQW  = 4'd1;
    localparam logic [3:0] S_ADD  = 4'd2;
    localparam logic [3:0] S_FIN  = 4'd3;
    localparam logic [3:0] S_M1W  = 4'd4;
    localparam logic [3:0] S_M1   = 4'd5;
    localparam logic [3:0] S_M2W  = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_NORM = 4'd8;
    localparam logic [3:0] S_LW   = 4'd9;
    localparam logic [3:0] S_LC   = 4'd10;
    localparam logic [3:0] S_DBW  = 4'd11;
    localparam logic [3:0] S_DB   = 4'd12;
    localparam logic [3:0] S_DIV  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0]       r_state;
    logic [4:0]       r_depth;
    t_sum             r_sum;
    logic [CW-1:0]    r_count;
    logic             r_sat;
    logic             r_last;
    logic             r_second;
    logic             r_ident;
    logic [31:0]      r_ma, r_mb;
    logic [63:0]      r_p;
    logic [63:0]      r_x;
    logic [5:0]       r_nsh;
    logic [4:0]       r_it;
    t_log             r_log, r_ln;
    t_psnr            r_psnr;
    logic [DVD_W-1:0] r_dvd;
    logic [CW-1:0]    r_rem;
    logic [5:0]       r_dcnt;
    logic             r_ov;
    logic [MSE_W-1:0] r_omse;
    t_psnr            r_opsnr;
    logic [1:0]       r_ouser;

    logic [4:0]  eff_d, sbits;
    logic [15:0] smask, maxv, pa, pb, diff;
    logic [54:0] sum_ext;
    logic [32:0] sq_v;
    logic [29:0] t_val;
    logic [63:0] db_sum;
    logic [19:0] db_q;
    logic [CW:0] trial;
    logic        out_free;

    always_comb begin
        eff_d = (r_depth == 5'd0) ? 5'd1 : ((r_depth > 5'd16) ? 5'd16 : r_depth);
        sbits = (eff_d < 5'(SAMPLE_BITS)) ? eff_d : 5'(SAMPLE_BITS);
        smask = 16'((17'd1 << sbits) - 17'd1);
        maxv  = 16'((17'd1 << eff_d) - 17'd1);
        pa    = i_s_tdata[15:0] & smask;
        pb    = i_s_tdata[31:16] & smask;
        diff  = (pa >= pb) ? (pa - pb) : (pb - pa);
        sum_ext = {1'b0, r_sum} + 55'(r_p[31:0]);
        sq_v  = r_p[63:31];
        t_val = (r_ln > r_log) ? (r_ln - r_log) : '0;
        db_sum = r_p + (64'd1 << 43);
        db_q  = db_sum[63:44];
        trial = {r_rem, r_dvd[DVD_W-1]} - {1'b0, r_count};
        out_free = !r_ov || i_m_tready;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {7'd0, r_opsnr, r_omse};
    assign o_m_tuser  = r_ouser;

    // Shared multiplier, always registered.
    always_ff @(posedge i_clk) begin
        r_p <= r_ma * r_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= DEPTH_RESET;
            r_sum   <= '0;
            r_count <= '0;
            r_sat   <= 1'b0;
            r_ov    <= 1'b0;
            r_last  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_depth <= i_cfg_wdata;
            end
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_last <= i_s_tlast;
                        if (r_count >= CW'(MAX_PIXELS)) begin
                            r_sat <= 1'b1;
                            r_state <= i_s_tlast ? S_FIN : S_IDLE;
                        end else begin
                            r_ma <= {16'd0, diff};
                            r_mb <= {16'd0, diff};
                            r_state <= S_SQW;
                        end
                    end
                end
                S_SQW: r_state <= S_ADD;
                S_ADD: begin
                    r_sum   <= sum_ext[54] ? '1 : sum_ext[53:0];
                    r_count <= r_count + 1'b1;
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_second <= 1'b0;
                    if (r_sum == '0 || r_count == '0) begin
                        r_ident <= 1'b1;
                        r_dvd   <= '0;
                        r_psnr  <= PSNR_IDENT;
                        r_state <= S_OUT;
                    end else begin
                        r_ident <= 1'b0;
                        r_ma <= {16'd0, maxv};
                        r_mb <= {16'd0, maxv};
                        r_state <= S_M1W;
                    end
                end
                S_M1W: r_state <= S_M1;
                S_M1: begin
                    r_ma <= r_p[31:0];
                    r_mb <= 32'(r_count);
                    r_state <= S_M2W;
                end
                S_M2W: r_state <= S_M2;
                S_M2: begin
                    r_x   <= r_p;
                    r_nsh <= '0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_x[63]) begin
                        r_log <= {6'(6'd63 - r_nsh), 24'd0};
                        r_ma  <= r_x[63:32];
                        r_mb  <= r_x[63:32];
                        r_it  <= 5'd23;
                        r_state <= S_LW;
                    end else begin
                        r_x   <= {r_x[62:0], 1'b0};
                        r_nsh <= r_nsh + 1'b1;
                    end
                end
                S_LW: r_state <= S_LC;
                S_LC: begin
                    // Squaring the mantissa doubles its log; an overflow past two
                    // yields the next fraction bit.
                    if (sq_v[32]) begin
                        r_ma <= sq_v[32:1];
                        r_mb <= sq_v[32:1];
                        r_log[r_it] <= 1'b1;
                    end else begin
                        r_ma <= sq_v[31:0];
                        r_mb <= sq_v[31:0];
                    end
                    if (r_it == 5'd0) begin
                        if (!r_second) begin
                            r_second <= 1'b1;
                            r_ln  <= r_log | (t_log'(sq_v[32]));
                            r_x   <= {10'd0, r_sum};
                            r_nsh <= '0;
                            r_state <= S_NORM;
                        end else begin
                            r_state <= S_DBW;
                        end
                    end else begin
                        r_it <= r_it - 1'b1;
                        r_state <= S_LW;
                    end
                end
                S_DBW: begin
                    r_ma <= {2'd0, t_val};
                    r_mb <= DB_SCALE;
                    r_state <= S_DB;
                end
                S_DB: begin
                    // Product of the DBW operands is registered in r_p here, ready for the divide state.
                    r_state <= S_DIV;
                    r_dvd  <= DVD_W'({r_sum, 8'd0}) + DVD_W'(r_count >> 1);
                    r_rem  <= '0;
                    r_dcnt <= 6'(DVD_W - 1);
                end
                S_DIV: begin
                    if (r_dcnt == 6'(DVD_W - 2)) begin
                        r_psnr <= (db_q > 20'd65535) ? 17'd65535 : 17'(db_q);
                    end
                    if (!trial[CW]) begin
                        r_rem <= trial[CW-1:0];
                    end else begin
                        r_rem <= {r_rem[CW-2:0], r_dvd[DVD_W-1]};
                    end
                    r_dvd <= {r_dvd[DVD_W-2:0], !trial[CW]};
                    if (r_dcnt == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_dcnt <= r_dcnt - 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_omse  <= r_dvd[MSE_W-1:0];
                        r_opsnr <= r_psnr;
                        r_ouser <= {r_sat, r_ident};
                        r_sum   <= '0;
                        r_count <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_ident_result, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata[39:0] == 40'd0 && o_m_tdata[56:40] == PSNR_IDENT)
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_PIXELS))
    `ASSERT_NEXT(a_clear_after_result, i_clk, i_rst_n, r_state == S_OUT && out_free, r_sum == '0 && r_count == '0 && !r_sat && o_m_tvalid)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
endmodule

### tb/image_mse_psnr_tb.sv
// Self-checking testbench for the image MSE/PSNR block.
module image_mse_psnr_tb;
    import imp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_PIX = 4194304;
    localparam logic [53:0] SUM_CAP = {54{1'b1}};

    typedef struct packed {
        logic [39:0] mse;
        logic [16:0] psnr;
        logic        ident;
        logic        ovf;
    } t_frame_res;

    typedef struct {
        logic [15:0] pa;
        logic [15:0] pb;
        logic        lst;
        logic        known;
        t_frame_res  res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // [15:0] pixel_a, [31:16] pixel_b
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;        // [39:0] mse, [56:40] psnr, rest zero
    logic [1:0]  o_m_tuser;        // [0] identical, [1] overflow

    image_mse_psnr dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state.
    logic [4:0]  depth_reg;
    logic [53:0] sq_sum;
    logic [22:0] pair_cnt;
    logic        cnt_sat;

    t_frame_res  pending_res[$];
    int          errors = 0;
    int          src_idle_pct = 15;
    int          snk_idle_pct = 71;
    int          hold_cycles = 0;

    function automatic logic [63:0] log2_fix(logic [63:0] x);
        int top;
        logic [63:0] m, r;
        logic [127:0] p;
        if (x == 0) return 0;
        top = 63;
        while (!x[top]) top--;
        m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
        r = 64'(top) << 24;
        for (int i = 23; i >= 0; i--) begin
            p = 128'(m) * 128'(m);
            m = 64'(p >> 31);
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    // Advance the accumulators by one pair; returns 1 with the frame result on a last pair.
    function automatic bit accumulate_pair(input logic [15:0] pa, input logic [15:0] pb,
                                           input logic lst, output t_frame_res res);
        int d;
        logic [15:0] msk, a, b, df;
        logic [63:0] sq, maxv, ln, ld, t;
        logic [127:0] prod;
        d = (depth_reg < 1) ? 1 : (depth_reg > 16) ? 16 : int'(depth_reg);
        msk = 16'((32'd1 << d) - 1);
        a = pa & msk;
        b = pb & msk;
        res = '0;
        if (pair_cnt >= MAX_PIX) cnt_sat = 1'b1;
        else begin
            df = (a >= b) ? a - b : b - a;
            sq = 64'(df) * 64'(df);
            if (64'(sq_sum) > 64'(SUM_CAP) - sq) sq_sum = SUM_CAP;
            else sq_sum = 54'(64'(sq_sum) + sq);
            pair_cnt++;
        end
        if (!lst) return 0;
        maxv = (64'd1 << d) - 1;
        if (sq_sum == 0 || pair_cnt == 0) begin
            res.mse = 0;
            res.psnr = PSNR_IDENT;
            res.ident = 1'b1;
        end else begin
            ln = log2_fix(maxv * maxv * 64'(pair_cnt));
            ld = log2_fix(64'(sq_sum));
            t = (ln > ld) ? ln - ld : 0;
            res.mse = 40'(((64'(sq_sum) << 8) + 64'(pair_cnt >> 1)) / 64'(pair_cnt));
            prod = (128'(t) * 128'(DB_SCALE) + (128'd1 << 43)) >> 44;
            res.psnr = (prod > 65535) ? 17'd65535 : 17'(prod);
        end
        res.ovf = cnt_sat;
        sq_sum = 0;
        pair_cnt = 0;
        cnt_sat = 0;
        return 1;
    endfunction

    // Valid stays high across back-to-back beats and drops only while idling.
    task automatic send_pair(input logic [15:0] pa, input logic [15:0] pb, input logic lst,
                             input logic known, input t_frame_res typed);
        t_frame_res res;
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pb, pa};
        i_s_tlast  <= lst;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (accumulate_pair(pa, pb, lst, res))
            pending_res.push_back(known ? typed : res);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    // Write the depth only while nothing is in flight.
    task automatic write_depth(input logic [4:0] v);
        drain_results();
        repeat (400) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        depth_reg = v;
    endtask

    task automatic random_frame(input int len);
        logic [15:0] pa, pb;
        int mode;
        mode = $urandom_range(3);
        for (int k = 0; k < len; k++) begin
            pa = 16'($urandom);
            case (mode)
                0: pb = pa;
                1: pb = pa ^ 16'($urandom_range(3));
                default: pb = 16'($urandom);
            endcase
            send_pair(pa, pb, k == len - 1, 1'b0, '0);
        end
    endtask

    // Receiver with random stalls and a long hold-off whenever hold_cycles is set.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready  <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame_res got, exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.mse   = o_m_tdata[39:0];
            got.psnr  = o_m_tdata[56:40];
            got.ident = o_m_tuser[0];
            got.ovf   = o_m_tuser[1];
            if (pending_res.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
            end else begin
                exp_r = pending_res.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, got);
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_row rows[$];
        logic [4:0] depths[6];
        int pass_cnt;
        depths = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd12, 5'd8};
        depth_reg = DEPTH_RESET;
        sq_sum = 0;
        pair_cnt = 0;
        cnt_sat = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset depth of 8.
        rows.push_back('{16'h0000, 16'h0000, 1'b1, 1'b1, '{0, PSNR_IDENT, 1'b1, 1'b0}});
        rows.push_back('{16'h00FF, 16'h00FF, 1'b1, 1'b1, '{0, PSNR_IDENT, 1'b1, 1'b0}});
        // Upper bits are masked off at depth 8, so this frame is identical too.
        rows.push_back('{16'hFF00, 16'h0100, 1'b1, 1'b1, '{0, PSNR_IDENT, 1'b1, 1'b0}});
        rows.push_back('{16'h00FF, 16'h0000, 1'b1, 1'b0, '0});
        rows.push_back('{16'h0000, 16'h00FF, 1'b0, 1'b0, '0});
        rows.push_back('{16'h0010, 16'h0011, 1'b1, 1'b0, '0});
        rows.push_back('{16'hFFFF, 16'h5555, 1'b0, 1'b0, '0});
        rows.push_back('{16'hAAAA, 16'h5555, 1'b0, 1'b0, '0});
        rows.push_back('{16'h0001, 16'h0000, 1'b1, 1'b0, '0});
        foreach (rows[i]) send_pair(rows[i].pa, rows[i].pb, rows[i].lst, rows[i].known,
                                    rows[i].res);

        for (pass_cnt = 0; pass_cnt < 3; pass_cnt++) begin
            if (pass_cnt == 1) begin
                src_idle_pct = 71;
                snk_idle_pct = 15;
            end else if (pass_cnt == 2) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            foreach (depths[j]) begin
                write_depth(depths[j]);
                // Full-scale difference frame at each depth.
                send_pair(16'hFFFF, 16'h0000, 1'b1, 1'b0, '0);
                for (int f = 0; f < 10; f++) random_frame($urandom_range(1, 17));
            end
            // Long hold-off on the result side while pairs keep coming.
            drain_results();
            hold_cycles = 3000;
            for (int f = 0; f < 4; f++) random_frame($urandom_range(1, 5));
        end

        drain_results();
        repeat (400) @(posedge i_clk);
        if (errors == 0 && pending_res.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
